// File: src/base_relocation_parser_unit_defines.svh
// assertion macros shared by the base relocation parser rtl
// expects clk and rst in the scope of every use
`ifndef BASE_RELOCATION_PARSER_UNIT_DEFINES_SVH
`define BASE_RELOCATION_PARSER_UNIT_DEFINES_SVH

// same-cycle implication
`define BRP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/brp_pkg.sv
// types and constants of the base relocation parser
// used by brp_parser, brp_out_queue and base_relocation_parser_unit
`timescale 1ns / 1ps

package brp_pkg;

  localparam int unsigned HeaderBytes    = 8;
  localparam int unsigned OffsetBits     = 12;
  localparam logic [3:0]  TypePadding    = 4'd0;
  localparam int unsigned QueueDepth     = 4;
  localparam int unsigned QueuePtrBits   = $clog2(QueueDepth);
  localparam int unsigned QueueCountBits = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    KindBlock = 2'd0,
    KindEntry = 2'd1,
    KindEnd   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    StatusNormal     = 2'd0,
    StatusSmallBlock = 2'd1,
    StatusPastEnd    = 2'd2
  } status_t;

  typedef struct packed {
    kind_t       record_kind;
    logic [31:0] address;
    logic [3:0]  reloc_type;
    logic [31:0] size_of_block;
    status_t     end_status;
    logic        last_of_run;
  } record_t;

  typedef struct packed {
    logic [1:0] count;
    record_t    rec0;
    record_t    rec1;
  } rec_pair_t;

endpackage

// File: src/brp_parser.sv
// per-byte parse of the relocation directory, up to two records per byte
// depends on brp_pkg and base_relocation_parser_unit_defines.svh
`timescale 1ns / 1ps
`include "base_relocation_parser_unit_defines.svh"

module brp_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              start_flag,
  input  logic [31:0]       directory_size,
  output brp_pkg::rec_pair_t recs
);

  logic [31:0] block_start_offset, block_start_offset_next;
  logic [31:0] block_end, block_end_next;
  logic [31:0] position_in_block, position_in_block_next;
  logic [31:0] current_page, current_page_next;
  logic [31:0] current_block_size, current_block_size_next;
  logic [7:0]  pending_low_byte, pending_low_byte_next;
  logic        finished, finished_next;

  logic [31:0] bso_e, bend_e, pos_e, page_e, size_e;
  logic [7:0]  pend_e;
  logic        fin_e;

  logic        in_header, at_first, at_last_hdr, tll_first, tll_hdr, tll_bend, tll_new;
  logic [31:0] page_upd, size_upd, pos_inc, new_bso, entry_addr;
  logic [32:0] end_sum;
  logic        past_dir, blk_done;
  logic [15:0] entry;
  logic [3:0]  entry_type;

  brp_pkg::record_t rec_a, rec_b;
  logic             a_valid, b_valid;
  logic             emits_end;

  function automatic brp_pkg::record_t end_rec(input brp_pkg::status_t st);
    brp_pkg::record_t r;
    r = '0;
    r.record_kind = brp_pkg::KindEnd;
    r.end_status  = st;
    return r;
  endfunction

  // start restarts the parse on this very byte
  assign bso_e  = start_flag ? '0 : block_start_offset;
  assign bend_e = start_flag ? '0 : block_end;
  assign pos_e  = start_flag ? '0 : position_in_block;
  assign page_e = start_flag ? '0 : current_page;
  assign size_e = start_flag ? '0 : current_block_size;
  assign pend_e = start_flag ? '0 : pending_low_byte;
  assign fin_e  = start_flag ? 1'b0 : finished;

  assign in_header   = (pos_e[31:3] == '0);
  assign at_first    = (pos_e == '0);
  assign at_last_hdr = (pos_e == 32'(brp_pkg::HeaderBytes - 1));
  assign tll_first   = ({1'b0, bso_e} + 33'(brp_pkg::HeaderBytes)) > {1'b0, directory_size};

  always_comb begin
    page_upd = at_first ? '0 : page_e;
    size_upd = at_first ? '0 : size_e;
    if (in_header) begin
      unique case (pos_e[2:0])
        3'd0: page_upd[7:0]   = data_byte;
        3'd1: page_upd[15:8]  = data_byte;
        3'd2: page_upd[23:16] = data_byte;
        3'd3: page_upd[31:24] = data_byte;
        3'd4: size_upd[7:0]   = data_byte;
        3'd5: size_upd[15:8]  = data_byte;
        3'd6: size_upd[23:16] = data_byte;
        3'd7: size_upd[31:24] = data_byte;
        default: ;
      endcase
    end
  end

  assign end_sum    = {1'b0, bso_e} + {1'b0, size_upd};
  assign past_dir   = end_sum > {1'b0, directory_size};
  assign entry      = {data_byte, pend_e};
  assign entry_type = entry[15:12];
  assign entry_addr = page_e + {20'd0, entry[brp_pkg::OffsetBits-1:0]};
  assign pos_inc    = pos_e + 32'd1;
  assign blk_done   = (!in_header || at_last_hdr) && (pos_inc == size_upd);

  // an eight-byte block ends on its last header byte
  assign new_bso  = at_last_hdr ? bso_e + 32'(brp_pkg::HeaderBytes) : bend_e;
  assign tll_hdr  = ({1'b0, bso_e} + 33'(2 * brp_pkg::HeaderBytes)) > {1'b0, directory_size};
  assign tll_bend = ({1'b0, bend_e} + 33'(brp_pkg::HeaderBytes)) > {1'b0, directory_size};
  assign tll_new  = at_last_hdr ? tll_hdr : tll_bend;

  always_comb begin
    rec_a   = '0;
    rec_b   = end_rec(brp_pkg::StatusNormal);
    a_valid = 1'b0;
    b_valid = 1'b0;
    block_start_offset_next = bso_e;
    block_end_next          = bend_e;
    position_in_block_next  = pos_e;
    current_page_next       = page_e;
    current_block_size_next = size_e;
    pending_low_byte_next   = pend_e;
    finished_next           = fin_e;
    if (!fin_e) begin
      if (at_first && tll_first) begin
        rec_a         = end_rec(brp_pkg::StatusNormal);
        a_valid       = 1'b1;
        finished_next = 1'b1;
      end else begin
        if (in_header) begin
          current_page_next       = page_upd;
          current_block_size_next = size_upd;
          if (at_last_hdr) begin
            block_end_next = end_sum[31:0];
            a_valid        = 1'b1;
            if (size_upd < 32'(brp_pkg::HeaderBytes)) begin
              rec_a         = end_rec(brp_pkg::StatusSmallBlock);
              finished_next = 1'b1;
            end else if (past_dir) begin
              rec_a         = end_rec(brp_pkg::StatusPastEnd);
              finished_next = 1'b1;
            end else begin
              rec_a.record_kind   = brp_pkg::KindBlock;
              rec_a.address       = page_upd;
              rec_a.size_of_block = size_upd;
            end
          end
        end else if (!pos_e[0]) begin
          pending_low_byte_next = data_byte;
        end else if (entry_type != brp_pkg::TypePadding) begin
          rec_a.record_kind = brp_pkg::KindEntry;
          rec_a.address     = entry_addr;
          rec_a.reloc_type  = entry_type;
          a_valid           = 1'b1;
        end
        if (!finished_next) begin
          if (blk_done) begin
            position_in_block_next  = '0;
            block_start_offset_next = new_bso;
            if (tll_new) begin
              b_valid       = 1'b1;
              finished_next = 1'b1;
            end
          end else begin
            position_in_block_next = pos_inc;
          end
        end
      end
    end
  end

  always_comb begin
    recs.count            = {a_valid & b_valid, a_valid ^ b_valid};
    recs.rec0             = a_valid ? rec_a : rec_b;
    recs.rec0.last_of_run = !(a_valid && b_valid);
    recs.rec1             = rec_b;
    recs.rec1.last_of_run = 1'b1;
  end

  assign emits_end = b_valid || (a_valid && rec_a.record_kind == brp_pkg::KindEnd);

  always_ff @(posedge clk) begin
    if (rst) begin
      block_start_offset <= '0;
      block_end          <= '0;
      position_in_block  <= '0;
      current_page       <= '0;
      current_block_size <= '0;
      pending_low_byte   <= '0;
      finished           <= 1'b0;
    end else if (accept) begin
      block_start_offset <= block_start_offset_next;
      block_end          <= block_end_next;
      position_in_block  <= position_in_block_next;
      current_page       <= current_page_next;
      current_block_size <= current_block_size_next;
      pending_low_byte   <= pending_low_byte_next;
      finished           <= finished_next;
    end
  end

  `BRP_ASSERT_IMP(a_quiet_when_done, finished && !start_flag, recs.count == 2'd0,
    "records produced after end of directory")
  `BRP_ASSERT_IMP(a_pair_ends, recs.count == 2'd2,
    recs.rec1.record_kind == brp_pkg::KindEnd, "second record of a byte is not an end")
  `BRP_ASSERT_NEXT(a_end_stops, accept && emits_end, finished,
    "parse not stopped after end record")

endmodule

// File: src/brp_out_queue.sv
// four-entry result queue taking up to two records per transaction
// depends on brp_pkg and base_relocation_parser_unit_defines.svh
`timescale 1ns / 1ps
`include "base_relocation_parser_unit_defines.svh"

module brp_out_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  brp_pkg::rec_pair_t recs,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output brp_pkg::record_t   out_rec
);

  localparam int unsigned PtrBits   = brp_pkg::QueuePtrBits;
  localparam int unsigned CountBits = brp_pkg::QueueCountBits;

  brp_pkg::record_t entries [brp_pkg::QueueDepth];

  logic [PtrBits-1:0]   head, tail, tail_plus;
  logic [CountBits-1:0] count;
  logic [1:0]           push_n;
  logic                 pop;

  assign push_n    = push ? recs.count : 2'd0;
  assign pop       = out_valid && out_ready;
  assign tail_plus = tail + PtrBits'(1);
  assign room      = count <= CountBits'(brp_pkg::QueueDepth - 2);
  assign out_valid = count != '0;
  assign out_rec   = entries[head];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entries[tail] <= recs.rec0;
    end
    if (push_n == 2'd2) begin
      entries[tail_plus] <= recs.rec1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + PtrBits'(push_n);
      head  <= head + PtrBits'(pop);
      count <= count + CountBits'(push_n) - CountBits'(pop);
    end
  end

  `BRP_ASSERT_IMP(a_no_overflow, 1'b1, count <= CountBits'(brp_pkg::QueueDepth),
    "queue count above depth")
  `BRP_ASSERT_IMP(a_push_fits, push_n != 2'd0,
    CountBits'(push_n) <= CountBits'(brp_pkg::QueueDepth) - count, "push into full queue")
  `BRP_ASSERT_NEXT(a_pop_only, pop && push_n == 2'd0, count == $past(count) - CountBits'(1),
    "count not reduced by a lone pop")

endmodule

// File: src/base_relocation_parser_unit.sv
// base relocation directory parser: byte stream in, block/entry/end records out
// records are written into the result queue and offered on m_axis from its head
// throughput: one byte per cycle; s_axis_tready drops while the four-entry result
// queue holds more than two records
// reset: synchronous rst clears directory_size, the parse state and the queue
// depends on brp_pkg, brp_parser and brp_out_queue
`timescale 1ns / 1ps

module base_relocation_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // start_flag
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // address, reloc_type, size_of_block, end_status, pad
  output logic [1:0]  m_axis_tuser,   // record_kind
  output logic        m_axis_tlast,   // last_of_run
  input  logic        cfg_wen,
  input  logic [31:0] cfg_wdata
);

  logic [31:0]        directory_size;
  logic               in_accept;
  brp_pkg::rec_pair_t recs;
  brp_pkg::record_t   out_rec;

  always_ff @(posedge clk) begin
    if (rst) begin
      directory_size <= '0;
    end else if (cfg_wen) begin
      directory_size <= cfg_wdata;
    end
  end

  assign in_accept = s_axis_tvalid && s_axis_tready;

  brp_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .accept         (in_accept),
    .data_byte      (s_axis_tdata),
    .start_flag     (s_axis_tuser),
    .directory_size (directory_size),
    .recs           (recs)
  );

  brp_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_accept),
    .recs      (recs),
    .room      (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_rec   (out_rec)
  );

  assign m_axis_tdata = {2'b00, out_rec.end_status, out_rec.size_of_block,
                         out_rec.reloc_type, out_rec.address};
  assign m_axis_tuser = out_rec.record_kind;
  assign m_axis_tlast = out_rec.last_of_run;

endmodule
